/* sv/lru_key_value_cache_core_macros.svh */
// Assertion shorthands used by the cache store RTL.
`ifndef LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lkvc_pkg.sv */
package lkvc_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = 5;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    typedef enum logic {
        REQ_GET = 1'b0,
        REQ_PUT = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic                     req_type;
        logic signed [KEY_W-1:0]  req_key;
        logic signed [VAL_W-1:0]  req_value;
    } t_req;

    typedef struct packed {
        logic                     hit;
        logic signed [VAL_W-1:0]  read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } t_rsp;

endpackage

/* sv/lkvc_store.sv */
`include "lru_key_value_cache_core_macros.svh"

module lkvc_store import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_req             i_req,
    input  logic [CFG_W-1:0] i_cap,
    output t_rsp             o_rsp
);

    logic [KEY_W-1:0]  r_key   [DEPTH];
    logic [VAL_W-1:0]  r_value [DEPTH];
    logic [RANK_W-1:0] r_rank  [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [OCC_W-1:0]  r_occ;

    logic [DEPTH-1:0]  hit_vec;
    logic [DEPTH-1:0]  lru_vec;
    logic [DEPTH-1:0]  free_vec;
    logic [DEPTH-1:0]  ins_vec;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] lru_rank;
    logic [VAL_W-1:0]  hit_value;
    logic [KEY_W-1:0]  lru_key;
    logic [31:0]       eff_cap;
    logic              hit;
    logic              is_put;
    logic              evict;
    logic              insert;

    assign is_put   = (i_req.req_type == REQ_PUT);
    // Valid ranks are always 0 .. occupancy-1, so the LRU entry holds occupancy-1.
    assign lru_rank = RANK_W'(r_occ - OCC_W'(1));

    always_comb begin
        if (i_cap == '0) begin
            eff_cap = 32'd1;
        end else if (32'(i_cap) > 32'(DEPTH)) begin
            eff_cap = 32'(DEPTH);
        end else begin
            eff_cap = 32'(i_cap);
        end
    end

    // Parallel tag match; valid keys are unique so each match vector has at most one bit set.
    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        lru_key   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i] = r_valid[i] && (r_key[i] == i_req.req_key);
            lru_vec[i] = r_valid[i] && (r_rank[i] == lru_rank);
            hit_rank   = hit_rank  | (r_rank[i]  & {RANK_W{hit_vec[i]}});
            hit_value  = hit_value | (r_value[i] & {VAL_W{hit_vec[i]}});
            lru_key    = lru_key   | (r_key[i]   & {KEY_W{lru_vec[i]}});
        end
    end

    assign hit      = |hit_vec;
    assign evict    = is_put && !hit && (32'(r_occ) >= eff_cap);
    assign insert   = is_put && !hit;
    // Lowest free slot: isolate the lowest set bit of the invalid mask.
    assign free_vec = ~r_valid & (r_valid + DEPTH'(1));
    assign ins_vec  = evict ? lru_vec : free_vec;

    always_comb begin
        o_rsp.hit         = hit;
        o_rsp.evicted     = evict;
        o_rsp.evicted_key = evict ? lru_key : '0;
        if (is_put) begin
            o_rsp.read_value = '0;
        end else if (hit) begin
            o_rsp.read_value = hit_value;
        end else begin
            o_rsp.read_value = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_en && insert) begin
            r_valid <= r_valid | ins_vec;
            if (!evict) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (hit) begin
                    if (hit_vec[i]) begin
                        r_rank[i] <= '0;
                        if (is_put) begin
                            r_value[i] <= i_req.req_value;
                        end
                    end else if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end else if (insert) begin
                    if (ins_vec[i]) begin
                        r_key[i]   <= i_req.req_key;
                        r_value[i] <= i_req.req_value;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    `LKVC_ASSERT_IMP(a_occ_count, i_clk, i_rst_n, 1'b1, $countones(r_valid) == 32'(r_occ), "occupancy does not match valid count")
    `LKVC_ASSERT_IMP(a_occ_max, i_clk, i_rst_n, 1'b1, 32'(r_occ) <= 32'(DEPTH), "occupancy above depth")
    `LKVC_ASSERT_IMP(a_evict_miss, i_clk, i_rst_n, evict, is_put && !hit && $onehot(lru_vec), "eviction without a single LRU put miss")
    `LKVC_ASSERT_NXT(a_occ_mono, i_clk, i_rst_n, 1'b1, r_occ >= $past(r_occ), "occupancy shrank")

endmodule

/* sv/lru_key_value_cache_core.sv */
// Channel   Direction  Handshake                    Payload
// req       in         i_req_valid / o_req_stall    i_req  (t_req)
// rsp       out        o_rsp_valid / i_rsp_stall    o_rsp  (t_rsp)
// cfg       in         i_cfg_we                     i_cfg_wdata (capacity in use)
//
// One request per cycle while the response is not stalled.
// The lookup, LRU rank update and eviction run in one pass between the
// request register and the response register.
// Synchronous active-low reset clears valid bits and occupancy, capacity goes to 16.
// A stalled response holds the request register, which then stalls the input.
module lru_key_value_cache_core import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_stall,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic             r_req_vld;
    t_req             r_req;
    logic             r_rsp_vld;
    t_rsp             r_rsp;
    logic [CFG_W-1:0] r_cap;

    logic out_free;
    logic proc_en;
    t_rsp rsp;

    assign out_free    = !r_rsp_vld || !i_rsp_stall;
    assign proc_en     = r_req_vld && out_free;
    assign o_req_stall = r_req_vld && !out_free;
    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

    lkvc_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_en),
        .i_req   (r_req),
        .i_cap   (r_cap),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
            r_rsp_vld <= 1'b0;
            r_cap     <= CFG_W'(16);
        end else begin
            if (!o_req_stall) begin
                r_req_vld <= i_req_valid;
            end
            if (out_free) begin
                r_rsp_vld <= r_req_vld;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_req <= i_req;
        end
        if (proc_en) begin
            r_rsp <= rsp;
        end
    end

endmodule

/* dv/lru_key_value_cache_core_checker.sv */
module lru_key_value_cache_core_checker import lkvc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_stall,
    input  t_req             i_req,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_stall,
    input  t_rsp             i_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_hit_count,
    output int               o_evict_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [KEY_W-1:0] slot_key  [DEPTH];
    logic [VAL_W-1:0] slot_val  [DEPTH];
    logic             slot_used [DEPTH];
    int               slot_age  [DEPTH];   // 0 is most recent
    int               fill;
    logic [CFG_W-1:0] capacity;
    t_rsp             due_answers[$];
    t_rsp             want;
    t_rsp             answer;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_hit_count   = 0;
        o_evict_count = 0;
        fill          = 0;
        capacity      = CFG_W'(DEPTH);
        for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
    end

    function automatic int room();
        int c;
        c = int'(capacity);
        if (c == 0) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    // Looks the key up, applies the put or eviction, updates the recency order and returns the response.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp a;
        int   hit_slot;
        int   tgt;
        int   age;
        a        = '0;
        hit_slot = -1;
        tgt      = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (slot_used[i] && slot_key[i] == r.req_key) begin
                hit_slot = i;
                break;
            end
        end
        if (hit_slot >= 0) begin
            a.hit = 1'b1;
            age = slot_age[hit_slot];
            for (int i = 0; i < DEPTH; i++)
                if (slot_used[i] && slot_age[i] < age) slot_age[i]++;
            slot_age[hit_slot] = 0;
            if (r.req_type == REQ_PUT) slot_val[hit_slot] = r.req_value;
            else a.read_value = slot_val[hit_slot];
        end else if (r.req_type == REQ_GET) begin
            a.read_value = '1;
        end else begin
            // full (or capacity lowered below occupancy): reuse the oldest slot
            if (fill >= room() && fill > 0) begin
                age = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (slot_used[i] && (tgt < 0 || slot_age[i] > age)) begin
                        tgt = i;
                        age = slot_age[i];
                    end
                end
                if (tgt >= 0) begin
                    a.evicted     = 1'b1;
                    a.evicted_key = slot_key[tgt];
                    slot_used[tgt] = 1'b0;
                    fill--;
                end
            end
            if (tgt < 0) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!slot_used[i]) begin
                        tgt = i;
                        break;
                    end
                end
            end
            if (tgt >= 0) begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot_used[i]) slot_age[i]++;
                slot_used[tgt] = 1'b1;
                slot_key[tgt]  = r.req_key;
                slot_val[tgt]  = r.req_value;
                slot_age[tgt]  = 0;
                fill++;
            end
        end
        return a;
    endfunction

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
            fill     = 0;
            capacity = CFG_W'(DEPTH);
            due_answers.delete();
        end else begin
            if (i_cfg_we) capacity = i_cfg_wdata;
            if (i_rsp_valid && !i_rsp_stall) begin
                if (due_answers.size() == 0) begin
                    $display("%0t: response with none expected, expected nothing, actual %h",
                             $time, i_rsp);
                    o_fail_count++;
                end else begin
                    want = due_answers.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_rsp.hit));
                    check_field("read_value", want.read_value, i_rsp.read_value);
                    check_field("evicted", 32'(want.evicted), 32'(i_rsp.evicted));
                    check_field("evicted_key", want.evicted_key, i_rsp.evicted_key);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                answer = apply_request(i_req);
                due_answers.push_back(answer);
                if (answer.hit) o_hit_count++;
                if (answer.evicted) o_evict_count++;
            end
        end
        o_pending = due_answers.size();
    end

endmodule

/* dv/tb_lru_key_value_cache_core.sv */
module tb_lru_key_value_cache_core import lkvc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_N = 24;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    t_req             req;
    logic             rsp_valid;
    logic             rsp_stall;
    t_rsp             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             quiet;      // no idling on either side while set
    int               fail_count;
    int               pending;
    int               hit_count;
    int               evict_count;
    int               sent;
    logic [KEY_W-1:0] key_pool [POOL_N];

    lru_key_value_cache_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    lru_key_value_cache_core_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_stall   (req_stall),
        .i_req         (req),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_stall   (rsp_stall),
        .i_rsp         (rsp),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_hit_count   (hit_count),
        .o_evict_count (evict_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(negedge clk) begin
        rsp_stall <= !quiet && ($urandom_range(99) < 36);
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_req make_req(input t_req_kind kind, input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v);
        t_req r;
        r.req_type  = kind;
        r.req_key   = k;
        r.req_value = v;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input t_req r);
        while (!quiet && $urandom_range(99) < 36) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] c);
        drain_responses();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Keys mostly come from the first pool_n pool entries so hits and evictions happen.
    task automatic random_items(input int n, input int pool_n);
        t_req r;
        for (int i = 0; i < n; i++) begin
            r.req_type  = ($urandom_range(1) != 0) ? REQ_PUT : REQ_GET;
            r.req_key   = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)]
                                                    : $urandom();
            r.req_value = $urandom();
            send_req(r);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_stall = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        quiet     = 1'b0;
        sent      = 0;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty miss, extreme keys and values, overwrite, eviction
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));
        send_req(make_req(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff));
        send_req(make_req(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000));
        send_req(make_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000));
        send_req(make_req(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff));
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'hffff_ffff));
        send_req(make_req(REQ_GET, 32'h7fff_ffff, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'hffff_ffff, 32'h0000_0000));
        send_req(make_req(REQ_PUT, 32'h0000_0000, 32'h5a5a_a5a5));
        send_req(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h1234_5678, 32'h0000_0000));
        // capacity below occupancy: each put miss swaps out one entry
        set_capacity(5'd2);
        send_req(make_req(REQ_PUT, 32'h1234_5678, 32'h0bad_cafe));
        send_req(make_req(REQ_PUT, 32'h0bad_cafe, 32'h1234_5678));
        send_req(make_req(REQ_GET, 32'h8000_0000, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h1234_5678, 32'h0000_0000));
        send_req(make_req(REQ_GET, 32'h0000_0000, 32'h0000_0000));

        set_capacity(5'd1);
        random_items(60, 6);
        set_capacity(5'd0);   // behaves as one
        random_items(40, 6);
        set_capacity(5'd4);
        random_items(110, 8);
        set_capacity(5'd31);  // saturates at full depth
        random_items(40, POOL_N);
        quiet <= 1'b1;
        random_items(80, POOL_N);
        quiet <= 1'b0;
        drain_responses();
        random_items(40, POOL_N);
        set_capacity(5'd2);
        random_items(90, 10);
        set_capacity(5'd16);
        random_items(80, 20);
        drain_responses();
        repeat (8) @(negedge clk);

        $display("Sent %0d requests over capacities 16, 2, 1, 0, 4, 31, 2 and 16;", sent);
        $display("%0d hits and %0d evictions predicted.", hit_count, evict_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/lkvc_pkg.sv
sv/lkvc_store.sv
sv/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_checker.sv
dv/tb_lru_key_value_cache_core.sv
